>>> hdl/wcwt_pkg.sv
`timescale 1ns / 1ps

package wcwt_pkg;

    // field widths
    localparam int CNT_W    = 32;
    localparam int HANDLE_W = 64;
    localparam int THREAD_W = 16;
    localparam int OP_W     = 2;
    localparam int KIND_W   = 3;

    // default table depth
    localparam int WCWT_SLOTS = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEC  = 2'd1;
    localparam logic [OP_W-1:0] OP_WAIT = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DONE     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STORED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MET      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd4;

    // commands from the sequencer to the slot table
    typedef struct packed {
        logic store;
        logic zero_target;
        logic scan_start;
        logic scan_pop;
    } slot_cmd_t;

    // status from the slot table
    typedef struct packed {
        logic has_free;
        logic pending;
    } slot_stat_t;

endpackage

>>> hdl/wcwt_slot_table.sv
`timescale 1ns / 1ps

module wcwt_slot_table
    import wcwt_pkg::*;
#(
    parameter int SLOTS = WCWT_SLOTS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  slot_cmd_t           cmd,
    input  logic [HANDLE_W-1:0] wr_handle,
    input  logic [THREAD_W-1:0] wr_thread,
    output slot_stat_t          stat,
    output logic [HANDLE_W-1:0] rd_handle,
    output logic [THREAD_W-1:0] rd_thread
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENT_W = HANDLE_W + THREAD_W;

    logic [SLOTS-1:0] busy_reg;
    logic [SLOTS-1:0] busy_next;
    logic [SLOTS-1:0] zero_reg;
    logic [SLOTS-1:0] zero_next;
    logic [SLOTS-1:0] pend_reg;
    logic [SLOTS-1:0] pend_next;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] pop_idx;
    logic [ENT_W-1:0] slot_mem [SLOTS];
    logic [ENT_W-1:0] rd_data_reg;

    // lowest free slot and lowest slot waiting for release
    always_comb
    begin
        free_idx = '0;
        pop_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (pend_reg[i])
            begin
                pop_idx = IDX_W'(i);
            end
        end
    end

    assign stat.has_free = ~&busy_reg;
    assign stat.pending  = |pend_reg;

    // slot occupancy and release list
    always_comb
    begin
        busy_next = busy_reg;
        zero_next = zero_reg;
        pend_next = pend_reg;
        if (cmd.store)
        begin
            busy_next[free_idx] = 1'b1;
            zero_next[free_idx] = cmd.zero_target;
        end
        if (cmd.scan_start)
        begin
            // every busy slot waiting for zero is freed now and listed
            pend_next = busy_reg & zero_reg;
            busy_next = busy_reg & ~zero_reg;
        end
        if (cmd.scan_pop)
        begin
            pend_next[pop_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
            zero_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            zero_reg <= zero_next;
            pend_reg <= pend_next;
        end
    end

    // waiter memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            slot_mem[free_idx] <= {wr_thread, wr_handle};
        end
        if (cmd.scan_pop)
        begin
            rd_data_reg <= slot_mem[pop_idx];
        end
    end

    assign rd_handle = rd_data_reg[HANDLE_W-1:0];
    assign rd_thread = rd_data_reg[ENT_W-1:HANDLE_W];

endmodule

>>> hdl/wait_counter_with_waiter_table.sv
`timescale 1ns / 1ps

// Wait counter with a table of SLOTS waiter slots. One input word is taken at a
// time. An add and a wait are accepted, then executed, which loads the result
// word. A decrement is accepted and executed, then takes a scan step before each
// word and a release step per released waiter, since each release reads the
// waiter memory through its registered read port before the result word is
// loaded; at most SLOTS release words then one done word with tlast. The next
// input word is taken once the last result of the previous one is in the output
// register, so a stalled consumer holds only that one word. Writing initial_count
// also loads the count, done by the user only while the block is idle (not enforced).
module wait_counter_with_waiter_table
    import wcwt_pkg::*;
#(
    parameter int SLOTS = WCWT_SLOTS
)
(
    input  logic          clk,
    input  logic          rst_n,
    // input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [143:0]  s_axis_tdata,   // amount, target_value, fiber_handle, pinned_thread
    input  logic [OP_W-1:0] s_axis_tuser, // operation
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [111:0]  m_axis_tdata,   // released_handle, released_thread, count_value
    output logic [KIND_W-1:0] m_axis_tuser, // result_kind
    output logic          m_axis_tlast,   // last
    // register port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_REL  = 3'd3;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    init_reg;
    logic [OP_W-1:0]     op_reg;
    logic [CNT_W-1:0]    amount_reg;
    logic [CNT_W-1:0]    target_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [THREAD_W-1:0] thread_reg;

    logic                ovalid_reg;
    logic                ovalid_next;
    logic [KIND_W-1:0]   okind_reg;
    logic [HANDLE_W-1:0] ohandle_reg;
    logic [THREAD_W-1:0] othread_reg;
    logic [CNT_W-1:0]    ocount_reg;
    logic                olast_reg;

    logic                load;
    logic [KIND_W-1:0]   load_kind;
    logic                load_rel;
    logic                load_last;
    logic                out_free;
    logic                in_acc;
    logic                cfg_wr;
    logic [CNT_W-1:0]    dec_val;

    slot_cmd_t           cmd;
    slot_stat_t          stat;
    logic [HANDLE_W-1:0] rd_handle;
    logic [THREAD_W-1:0] rd_thread;

    wcwt_slot_table #(
        .SLOTS (SLOTS)
    ) u_slots (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr_handle (handle_reg),
        .wr_thread (thread_reg),
        .stat      (stat),
        .rd_handle (rd_handle),
        .rd_thread (rd_thread)
    );

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? '0 : init_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign dec_val       = count_reg - CNT_W'(1);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        load       = 1'b0;
        load_kind  = KIND_DONE;
        load_rel   = 1'b0;
        load_last  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        if (out_free)
                        begin
                            count_next = count_reg + amount_reg;
                            load       = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    OP_DEC:
                    begin
                        count_next     = dec_val;
                        cmd.scan_start = (dec_val == '0);
                        state_next     = S_SCAN;
                    end
                    OP_WAIT:
                    begin
                        if (out_free)
                        begin
                            load       = 1'b1;
                            state_next = S_IDLE;
                            // a full table rejects the wait before the target is looked at
                            if (!stat.has_free)
                            begin
                                load_kind = KIND_FULL;
                            end
                            else if (target_reg == count_reg)
                            begin
                                load_kind = KIND_MET;
                            end
                            else
                            begin
                                load_kind       = KIND_STORED;
                                cmd.store       = 1'b1;
                                cmd.zero_target = (target_reg == '0);
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.pending)
                begin
                    cmd.scan_pop = 1'b1;
                    state_next   = S_REL;
                end
                else if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REL:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    load_kind  = KIND_RELEASED;
                    load_rel   = 1'b1;
                    load_last  = 1'b0;
                    state_next = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // a register write reloads the count
        if (cfg_wr)
        begin
            count_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            init_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr)
            begin
                init_reg <= pwdata;
            end
        end
    end

    // input word capture
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg     <= s_axis_tuser;
            amount_reg <= s_axis_tdata[31:0];
            target_reg <= s_axis_tdata[63:32];
            handle_reg <= s_axis_tdata[127:64];
            thread_reg <= s_axis_tdata[143:128];
        end
    end

    // output register
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end
        if (load)
        begin
            ovalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            okind_reg   <= load_kind;
            ohandle_reg <= load_rel ? rd_handle : '0;
            othread_reg <= load_rel ? rd_thread : '0;
            ocount_reg  <= count_next;
            olast_reg   <= load_last;
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {ocount_reg, othread_reg, ohandle_reg};

`ifndef SYNTH
    // a release word always reports a count of zero and is never the last word
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_RELEASED)
        |-> (m_axis_tdata[111:80] == '0 && !m_axis_tlast))
        else $error("release word with nonzero count or tlast");

    // releases are only pending while the count sits at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (stat.pending) |-> (count_reg == '0))
        else $error("pending release with nonzero count");

    // an accepted input word goes straight to execution
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == S_EXEC))
        else $error("accepted word not executed");

    // a memory read is only issued with a release pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_pop) |-> (state_reg == S_SCAN && stat.pending))
        else $error("slot read without pending release");
`endif

endmodule
